[rtl/core/ilnf_pkg.sv]
package ilnf_pkg;

  localparam int DEF_HEAP_WORDS  = 16384;
  localparam int DEF_CHUNK_BYTES = 4096;

  localparam logic [31:0] SIZE_MASK  = ~32'h7;
  localparam logic [31:0] ALLOC_BIT  = 32'h1;
  localparam logic [31:0] HEAP_START = 32'd8;
  localparam logic [31:0] PRO_TAG    = 32'd9;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_FR_RD,
    S_FR_CHK,
    S_FR_CMP,
    S_FR_W2,
    S_FIT_RD,
    S_FIT_CHK,
    S_GROW,
    S_GROW_W2,
    S_GROW_W3,
    S_MG_RD0,
    S_MG_RD1,
    S_MG_RD2,
    S_MG_RD3,
    S_MG_CASE,
    S_MG_W2,
    S_MG_RD4,
    S_MG_ROV,
    S_PL_RD,
    S_PL_CHK,
    S_PL_W2,
    S_PL_W3,
    S_PL_W4,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        en;
    logic        we;
    logic [31:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

endpackage

[rtl/core/ilnf_heap_mem.sv]
module ilnf_heap_mem #(
  parameter int HEAP_WORDS = ilnf_pkg::DEF_HEAP_WORDS
) (
  input  logic              clk,
  input  ilnf_pkg::mem_req_t req,
  output logic [31:0]       rdata
);
  import ilnf_pkg::*;

  localparam int IW = $clog2(HEAP_WORDS);

  logic [31:0] mem [HEAP_WORDS];
  logic [31:0] mem_q_r;
  logic        oor_r;
  logic        in_range;
  logic [IW-1:0] idx;

  // Byte addresses past the array read as zero and drop writes.
  assign in_range = (req.addr[31:2] < 30'(HEAP_WORDS));
  assign idx      = req.addr[IW+1:2];

  always_ff @(posedge clk) begin
    if (req.en && req.we && in_range) begin
      mem[idx] <= req.wdata;
    end
    if (req.en && !req.we) begin
      if (in_range) begin
        mem_q_r <= mem[idx];
      end
      oor_r <= !in_range;
    end
  end

  assign rdata = oor_r ? 32'd0 : mem_q_r;

endmodule

[rtl/core/implicit_list_next_fit_allocator.sv]
// Next-fit heap allocator with boundary tags kept in one single-port word memory.
// After reset a clearing pass writes every one of the HEAP_WORDS words and no
// transaction is taken until it ends. A free checks the block's header and footer,
// rewrites both as free and coalesces with free neighbors before the next transaction
// can be taken. An allocate runs the next-fit search over the block tags, then places
// the block and returns the result, growing the heap and merging first when it must.
// Every tag access goes through the one memory port, whose reads are registered.
// One operation is in flight at a time; the result register lets a new one start
// while it waits.
module implicit_list_next_fit_allocator #(
  parameter int HEAP_WORDS  = ilnf_pkg::DEF_HEAP_WORDS,
  parameter int CHUNK_BYTES = ilnf_pkg::DEF_CHUNK_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_req_bytes,
  input  logic [15:0] in_free_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_block_addr,
  output logic        out_ok
);
  import ilnf_pkg::*;

  localparam int IW = $clog2(HEAP_WORDS);
  localparam int NW = $clog2(HEAP_WORDS + 1);
  localparam logic [31:0] HEAP_BYTES = 32'(HEAP_WORDS * 4);
  localparam logic [31:0] CHUNK_EVEN = 32'((((CHUNK_BYTES / 4) + ((CHUNK_BYTES / 4) % 2)) * 4));
  localparam logic CHUNK_FITS = (CHUNK_EVEN <= HEAP_BYTES - 32'd16);
  localparam logic [31:0] END_INIT = CHUNK_FITS ? (32'd16 + CHUNK_EVEN) : 32'd16;
  localparam logic [31:0] FTR_IDX = (CHUNK_EVEN + 32'd8) >> 2;
  localparam logic [31:0] EPI_IDX = (CHUNK_EVEN + 32'd12) >> 2;

  state_t state_r, state_nxt;
  mem_req_t mreq;
  logic [31:0] q, qs;

  logic [IW-1:0] clr_r, clr_nxt;
  logic        is_alloc_r, is_alloc_nxt;
  logic [16:0] asize_r, asize_nxt;
  logic [15:0] fa_r, fa_nxt;
  logic [31:0] bp_r, bp_nxt;
  logic [31:0] rover_r, rover_nxt;
  logic [31:0] heap_end_r, heap_end_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic        pass2_r, pass2_nxt;
  logic [31:0] msz_r, msz_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [31:0] psz_r, psz_nxt;
  logic        pa_r, pa_nxt;
  logic [31:0] next_r, next_nxt;
  logic [31:0] wa_r, wa_nxt;
  logic [31:0] wd_r, wd_nxt;
  logic [31:0] tot_r, tot_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        split_r, split_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [15:0] res_addr_r, res_addr_nxt;
  logic        res_ok_r, res_ok_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_addr_r, out_addr_nxt;
  logic        out_ok_r, out_ok_nxt;

  logic [31:0] asize32, fa32, gsize, clr_word, init_val, pl_rem;
  logic        pass_end, fit_hit, grow_fail, fr_pass, rov_in, out_free;

  ilnf_heap_mem #(.HEAP_WORDS(HEAP_WORDS)) u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (q)
  );

  assign qs       = q & SIZE_MASK;
  assign asize32  = {15'd0, asize_r};
  assign fa32     = {16'd0, fa_r};
  assign out_free = !out_valid_r || !out_stall;
  assign clr_word = {{(32 - IW){1'b0}}, clr_r};
  assign pass_end = (n_r == NW'(HEAP_WORDS)) || (pass2_r && (bp_r == rover_r));
  assign fit_hit  = !q[0] && (qs >= asize32);
  assign gsize    = (asize32 > 32'(CHUNK_BYTES)) ? asize32 : CHUNK_EVEN;
  assign grow_fail = gsize > (HEAP_BYTES - heap_end_r);
  assign rov_in   = (rover_r > bp_r) && (rover_r < bp_r + qs);
  assign pl_rem   = qs - asize32;
  assign fr_pass  = (fa_r[2:0] == 3'd0) && (fa32 >= HEAP_START + 32'd8) &&
                    (fa32 < heap_end_r) && q[0] && (q[2:1] == 2'd0) &&
                    (qs >= 32'd16) && (qs <= heap_end_r - fa32);

  always_comb begin
    init_val = 32'd0;
    if (clr_word == 32'd1 || clr_word == 32'd2) begin
      init_val = PRO_TAG;
    end else if (clr_word == 32'd3) begin
      init_val = CHUNK_FITS ? CHUNK_EVEN : ALLOC_BIT;
    end else if (CHUNK_FITS && clr_word == FTR_IDX) begin
      init_val = CHUNK_EVEN;
    end else if (CHUNK_FITS && clr_word == EPI_IDX) begin
      init_val = ALLOC_BIT;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   if (clr_r == IW'(HEAP_WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_FREE) begin
            state_nxt = S_FR_RD;
          end else if (in_req_bytes == 16'd0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FIT_RD;
          end
        end
      end
      S_FR_RD:   state_nxt = S_FR_CHK;
      S_FR_CHK:  state_nxt = fr_pass ? S_FR_CMP : S_DONE;
      S_FR_CMP:  state_nxt = (q == hdr_r) ? S_FR_W2 : S_DONE;
      S_FR_W2:   state_nxt = S_MG_RD0;
      S_FIT_RD: begin
        if (!pass_end) begin
          state_nxt = S_FIT_CHK;
        end else if (pass2_r) begin
          state_nxt = S_GROW;
        end
      end
      S_FIT_CHK: begin
        priority if (qs == 32'd0) begin
          state_nxt = pass2_r ? S_GROW : S_FIT_RD;
        end else if (fit_hit) begin
          state_nxt = S_PL_RD;
        end else begin
          state_nxt = S_FIT_RD;
        end
      end
      S_GROW:    state_nxt = grow_fail ? S_DONE : S_GROW_W2;
      S_GROW_W2: state_nxt = S_GROW_W3;
      S_GROW_W3: state_nxt = S_MG_RD0;
      S_MG_RD0:  state_nxt = S_MG_RD1;
      S_MG_RD1:  state_nxt = S_MG_RD2;
      S_MG_RD2:  state_nxt = S_MG_RD3;
      S_MG_RD3:  state_nxt = S_MG_CASE;
      S_MG_CASE: state_nxt = (pa_r && q[0]) ? S_MG_RD4 : S_MG_W2;
      S_MG_W2:   state_nxt = S_MG_RD4;
      S_MG_RD4:  state_nxt = S_MG_ROV;
      S_MG_ROV: begin
        if (is_alloc_r && bp_r != 32'd0) begin
          state_nxt = S_PL_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PL_RD:   state_nxt = S_PL_CHK;
      S_PL_CHK:  state_nxt = S_PL_W2;
      S_PL_W2:   state_nxt = split_r ? S_PL_W3 : S_DONE;
      S_PL_W3:   state_nxt = S_PL_W4;
      S_PL_W4:   state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Memory requests and datapath.
  always_comb begin
    mreq          = '0;
    clr_nxt       = clr_r;
    is_alloc_nxt  = is_alloc_r;
    asize_nxt     = asize_r;
    fa_nxt        = fa_r;
    bp_nxt        = bp_r;
    rover_nxt     = rover_r;
    heap_end_nxt  = heap_end_r;
    n_nxt         = n_r;
    pass2_nxt     = pass2_r;
    msz_nxt       = msz_r;
    prev_nxt      = prev_r;
    psz_nxt       = psz_r;
    pa_nxt        = pa_r;
    next_nxt      = next_r;
    wa_nxt        = wa_r;
    wd_nxt        = wd_r;
    tot_nxt       = tot_r;
    rem_nxt       = rem_r;
    split_nxt     = split_r;
    hdr_nxt       = hdr_r;
    res_addr_nxt  = res_addr_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_ok_nxt    = out_ok_r;
    unique case (state_r)
      S_CLEAR: begin
        mreq    = '{en: 1'b1, we: 1'b1, addr: {clr_word[29:0], 2'b00}, wdata: init_val};
        clr_nxt = clr_r + IW'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          is_alloc_nxt = (in_op == OP_ALLOC);
          asize_nxt    = (in_req_bytes <= 16'd8) ? 17'd16 :
                         (({1'b0, in_req_bytes} + 17'd15) & ~17'h7);
          fa_nxt       = in_free_addr;
          bp_nxt       = rover_r;
          n_nxt        = '0;
          pass2_nxt    = 1'b0;
          res_addr_nxt = 16'd0;
          res_ok_nxt   = 1'b0;
        end
      end
      S_FR_RD: mreq = '{en: 1'b1, we: 1'b0, addr: fa32 - 32'd4, wdata: 32'd0};
      S_FR_CHK: begin
        hdr_nxt = q;
        tot_nxt = qs;
        if (fr_pass) begin
          mreq = '{en: 1'b1, we: 1'b0, addr: fa32 + qs - 32'd8, wdata: 32'd0};
        end
      end
      S_FR_CMP: begin
        if (q == hdr_r) begin
          mreq = '{en: 1'b1, we: 1'b1, addr: fa32 - 32'd4, wdata: tot_r};
        end
      end
      S_FR_W2: begin
        mreq   = '{en: 1'b1, we: 1'b1, addr: fa32 + tot_r - 32'd8, wdata: tot_r};
        bp_nxt = fa32;
      end
      S_FIT_RD: begin
        if (!pass_end) begin
          mreq = '{en: 1'b1, we: 1'b0, addr: bp_r - 32'd4, wdata: 32'd0};
        end else if (!pass2_r) begin
          pass2_nxt = 1'b1;
          bp_nxt    = HEAP_START;
          n_nxt     = '0;
        end
      end
      S_FIT_CHK: begin
        priority if (qs == 32'd0) begin
          pass2_nxt = 1'b1;
          bp_nxt    = HEAP_START;
          n_nxt     = '0;
        end else if (fit_hit) begin
          rover_nxt = bp_r;
        end else begin
          bp_nxt = bp_r + qs;
          n_nxt  = n_r + NW'(1);
        end
      end
      S_GROW: begin
        if (!grow_fail) begin
          mreq   = '{en: 1'b1, we: 1'b1, addr: heap_end_r - 32'd4, wdata: gsize};
          bp_nxt = heap_end_r;
          wd_nxt = gsize;
        end
      end
      S_GROW_W2: mreq = '{en: 1'b1, we: 1'b1, addr: bp_r + wd_r - 32'd8, wdata: wd_r};
      S_GROW_W3: begin
        mreq         = '{en: 1'b1, we: 1'b1, addr: bp_r + wd_r - 32'd4, wdata: ALLOC_BIT};
        heap_end_nxt = bp_r + wd_r;
      end
      S_MG_RD0: mreq = '{en: 1'b1, we: 1'b0, addr: bp_r - 32'd4, wdata: 32'd0};
      S_MG_RD1: begin
        msz_nxt = qs;
        mreq    = '{en: 1'b1, we: 1'b0, addr: bp_r - 32'd8, wdata: 32'd0};
      end
      S_MG_RD2: begin
        prev_nxt = bp_r - qs;
        mreq     = '{en: 1'b1, we: 1'b0, addr: bp_r - qs - 32'd4, wdata: 32'd0};
      end
      S_MG_RD3: begin
        pa_nxt   = q[0];
        psz_nxt  = qs;
        next_nxt = bp_r + msz_r;
        mreq     = '{en: 1'b1, we: 1'b0, addr: bp_r + msz_r - 32'd4, wdata: 32'd0};
      end
      S_MG_CASE: begin
        // Coalesce with whichever neighbors are free.
        priority if (pa_r && q[0]) begin
        end else if (pa_r) begin
          mreq   = '{en: 1'b1, we: 1'b1, addr: bp_r - 32'd4, wdata: msz_r + qs};
          wa_nxt = bp_r + msz_r + qs - 32'd8;
          wd_nxt = msz_r + qs;
        end else if (q[0]) begin
          mreq   = '{en: 1'b1, we: 1'b1, addr: next_r - 32'd8, wdata: msz_r + psz_r};
          wa_nxt = prev_r - 32'd4;
          wd_nxt = msz_r + psz_r;
          bp_nxt = prev_r;
        end else begin
          mreq   = '{en: 1'b1, we: 1'b1, addr: prev_r - 32'd4, wdata: msz_r + psz_r + qs};
          wa_nxt = next_r + qs - 32'd8;
          wd_nxt = msz_r + psz_r + qs;
          bp_nxt = prev_r;
        end
      end
      S_MG_W2:  mreq = '{en: 1'b1, we: 1'b1, addr: wa_r, wdata: wd_r};
      S_MG_RD4: mreq = '{en: 1'b1, we: 1'b0, addr: bp_r - 32'd4, wdata: 32'd0};
      S_MG_ROV: begin
        if (rov_in) begin
          rover_nxt = bp_r;
        end
        if (!is_alloc_r) begin
          res_ok_nxt = 1'b1;
        end
      end
      S_PL_RD: mreq = '{en: 1'b1, we: 1'b0, addr: bp_r - 32'd4, wdata: 32'd0};
      S_PL_CHK: begin
        tot_nxt   = qs;
        rem_nxt   = pl_rem;
        split_nxt = (pl_rem >= 32'd8);
        mreq      = '{en: 1'b1, we: 1'b1, addr: bp_r - 32'd4,
                      wdata: (pl_rem >= 32'd8) ? (asize32 | ALLOC_BIT) : (qs | ALLOC_BIT)};
      end
      S_PL_W2: begin
        if (split_r) begin
          mreq = '{en: 1'b1, we: 1'b1, addr: bp_r + asize32 - 32'd8,
                   wdata: asize32 | ALLOC_BIT};
        end else begin
          mreq = '{en: 1'b1, we: 1'b1, addr: bp_r + tot_r - 32'd8, wdata: tot_r | ALLOC_BIT};
          res_addr_nxt = bp_r[15:0];
          res_ok_nxt   = 1'b1;
        end
      end
      S_PL_W3: mreq = '{en: 1'b1, we: 1'b1, addr: bp_r + asize32 - 32'd4, wdata: rem_r};
      S_PL_W4: begin
        mreq         = '{en: 1'b1, we: 1'b1, addr: bp_r + tot_r - 32'd8, wdata: rem_r};
        res_addr_nxt = bp_r[15:0];
        res_ok_nxt   = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_ok_nxt    = res_ok_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rover_r     <= HEAP_START;
      heap_end_r  <= END_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rover_r     <= rover_nxt;
      heap_end_r  <= heap_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_alloc_r <= is_alloc_nxt;
    asize_r    <= asize_nxt;
    fa_r       <= fa_nxt;
    bp_r       <= bp_nxt;
    n_r        <= n_nxt;
    pass2_r    <= pass2_nxt;
    msz_r      <= msz_nxt;
    prev_r     <= prev_nxt;
    psz_r      <= psz_nxt;
    pa_r       <= pa_nxt;
    next_r     <= next_nxt;
    wa_r       <= wa_nxt;
    wd_r       <= wd_nxt;
    tot_r      <= tot_nxt;
    rem_r      <= rem_nxt;
    split_r    <= split_nxt;
    hdr_r      <= hdr_nxt;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    out_addr_r <= out_addr_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_block_addr = out_addr_r;
  assign out_ok         = out_ok_r;

  a_heap_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
    heap_end_r <= HEAP_BYTES)
    else $error("heap end passed the memory size");

  a_heap_end_align: assert property (@(posedge clk) disable iff (!rst_n)
    heap_end_r[2:0] == 3'd0)
    else $error("heap end lost its 8-byte alignment");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (in_stall && mreq.we))
    else $error("transaction taken or write missed during clearing pass");

  a_idle_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mreq.en)
    else $error("memory access while idle");

endmodule
